// ----- src/wsd_pkg.sv -----
// Package for the WebSocket frame decoder: shared widths, defaults and the
// result word type. No dependencies.
package wsd_pkg;

  localparam int WSD_LENGTH_WIDTH = 63;  // default width of the length counters
  localparam int WSD_FRAME_LEN_W  = 63;  // width of frame_length on the result channel

  typedef struct packed {
    logic [7:0]                 payload_byte;
    logic                       fin;
    logic [3:0]                 opcode;
    logic                       was_masked;
    logic [WSD_FRAME_LEN_W-1:0] frame_length;
    logic                       last_of_frame;
    logic                       empty_frame;
  } wsd_result_t;

endpackage

// ----- src/wsd_if.sv -----
// Handshake channels of the WebSocket frame decoder: raw byte input and
// decoded result output. Depends on wsd_pkg.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsd_out_if
  import wsd_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 payload_byte;
  logic                       fin;
  logic [3:0]                 opcode;
  logic                       was_masked;
  logic [WSD_FRAME_LEN_W-1:0] frame_length;
  logic                       last_of_frame;
  logic                       empty_frame;

  modport source (output valid, output payload_byte, output fin, output opcode,
                  output was_masked, output frame_length, output last_of_frame,
                  output empty_frame, input ready);
  modport sink   (input valid, input payload_byte, input fin, input opcode,
                  input was_masked, input frame_length, input last_of_frame,
                  input empty_frame, output ready);
endinterface

// ----- src/wsd_parser.sv -----
// Frame header parser and payload unmasker: holds the per-frame state and
// turns one byte into at most one result word. Depends on wsd_pkg.
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int LENGTH_WIDTH = WSD_LENGTH_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,       // byte below is consumed this cycle
  input  logic [7:0]  data_byte,
  output logic        res_valid,
  output wsd_result_t res
);

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXTLEN = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;

  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [6:0] LEN_EXT16 = 7'd126;

  logic [2:0]              phase_r, phase_nxt;
  logic [2:0]              hdr_cnt_r, hdr_cnt_nxt;
  logic                    fin_r, fin_nxt;
  logic [3:0]              opcode_r, opcode_nxt;
  logic                    masked_r, masked_nxt;
  logic [31:0]             key_r, key_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic [LENGTH_WIDTH-1:0] rem_r, rem_nxt;
  logic [1:0]              key_idx_r, key_idx_nxt;

  logic [7:0] key_byte;
  logic       hdr_end;    // header complete after this byte
  logic       last;

  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    fin_nxt     = fin_r;
    opcode_nxt  = opcode_r;
    masked_nxt  = masked_r;
    key_nxt     = key_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    key_idx_nxt = key_idx_r;
    hdr_end     = 1'b0;
    last        = 1'b0;
    res_valid   = 1'b0;
    res.payload_byte = 8'h00;

    unique case (phase_r)
      PH_HDR0: begin
        fin_nxt    = data_byte[7];
        opcode_nxt = data_byte[3:0];
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = data_byte[7];
        key_nxt    = '0;
        if (data_byte[6:0] == LEN_EXT64) begin
          len_nxt     = '0;
          hdr_cnt_nxt = 3'd0;   // wraps: eight length bytes
          phase_nxt   = PH_EXTLEN;
        end else if (data_byte[6:0] == LEN_EXT16) begin
          len_nxt     = '0;
          hdr_cnt_nxt = 3'd2;
          phase_nxt   = PH_EXTLEN;
        end else begin
          len_nxt = LENGTH_WIDTH'(data_byte[6:0]);
          if (data_byte[7]) begin
            hdr_cnt_nxt = 3'd4;
            phase_nxt   = PH_KEY;
          end else begin
            hdr_cnt_nxt = 3'd0;
            hdr_end     = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        // bits above the counter width fall off the top
        len_nxt     = {len_r[LENGTH_WIDTH-9:0], data_byte};
        hdr_cnt_nxt = hdr_cnt_r - 3'd1;
        if (hdr_cnt_nxt == 3'd0) begin
          if (masked_r) begin
            hdr_cnt_nxt = 3'd4;
            phase_nxt   = PH_KEY;
          end else begin
            hdr_end = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_nxt     = {key_r[23:0], data_byte};
        hdr_cnt_nxt = hdr_cnt_r - 3'd1;
        if (hdr_cnt_nxt == 3'd0) begin
          hdr_end = 1'b1;
        end
      end
      PH_BODY: begin
        key_idx_nxt = key_idx_r + 2'd1;
        if (rem_r != '0) begin
          rem_nxt = rem_r - LENGTH_WIDTH'(1);
        end
        last             = (rem_nxt == '0);
        res_valid        = 1'b1;
        res.payload_byte = data_byte ^ (masked_r ? key_byte : 8'h00);
        if (last) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase

    if (hdr_end) begin
      if (len_nxt == '0) begin
        res_valid = 1'b1;
        last      = 1'b1;
        phase_nxt = PH_HDR0;
      end else begin
        rem_nxt     = len_nxt;
        key_idx_nxt = 2'd0;
        phase_nxt   = PH_BODY;
      end
    end

    res.fin           = fin_nxt;
    res.opcode        = opcode_nxt;
    res.was_masked    = masked_nxt;
    res.frame_length  = WSD_FRAME_LEN_W'(len_nxt);
    res.last_of_frame = last;
    res.empty_frame   = hdr_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      hdr_cnt_r <= '0;
      fin_r     <= 1'b0;
      opcode_r  <= '0;
      masked_r  <= 1'b0;
      key_r     <= '0;
      len_r     <= '0;
      rem_r     <= '0;
      key_idx_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      fin_r     <= fin_nxt;
      opcode_r  <= opcode_nxt;
      masked_r  <= masked_nxt;
      key_r     <= key_nxt;
      len_r     <= len_nxt;
      rem_r     <= rem_nxt;
      key_idx_r <= key_idx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> rem_r != '0)
    else $error("body phase with nothing left to deliver");

  a_data_from_body: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.empty_frame |-> phase_r == PH_BODY)
    else $error("payload word outside the body");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.empty_frame |-> res.last_of_frame && len_nxt == '0)
    else $error("empty-frame word malformed");

  a_hdr0_advances: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_HDR0 |=> phase_r == PH_HDR1)
    else $error("first header byte did not advance the parser");
`endif

endmodule

// ----- src/websocket_frame_decoder.sv -----
// WebSocket frame decoder: takes the received stream one byte per cycle while
// the output is not stalled, and issues one result word per payload byte
// (unmasked, with fin, opcode, mask flag and declared length), one
// empty-frame word for a zero-length frame, and nothing for header bytes.
// Header parsing and unmasking are one combinational step; a result word
// passes through the input register, then the result register. in_if.ready
// drops only while a result is held in the output register and not taken.
module websocket_frame_decoder
  import wsd_pkg::*;
#(
  parameter int LENGTH_WIDTH = WSD_LENGTH_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  wsd_in_if.sink            in_if,
  wsd_out_if.source         out_if
);

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        out_vld_r, out_vld_nxt;
  wsd_result_t out_r;
  logic        out_blocked;
  logic        adv;
  logic        res_valid;
  wsd_result_t res;

  assign out_blocked = out_vld_r && !out_if.ready;
  assign adv         = in_vld_r && !out_blocked;
  assign in_if.ready = !in_vld_r || !out_blocked;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_if.valid && in_if.ready) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv && res_valid) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.data_byte;
    end
    if (adv && res_valid) begin
      out_r <= res;
    end
  end

  wsd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .data_byte (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_if.valid         = out_vld_r;
  assign out_if.payload_byte  = out_r.payload_byte;
  assign out_if.fin           = out_r.fin;
  assign out_if.opcode        = out_r.opcode;
  assign out_if.was_masked    = out_r.was_masked;
  assign out_if.frame_length  = out_r.frame_length;
  assign out_if.last_of_frame = out_r.last_of_frame;
  assign out_if.empty_frame   = out_r.empty_frame;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for websocket_frame_decoder: drives framed byte
// streams, predicts each result word and checks it on the result channel.
// Depends on wsd_pkg, wsd_in_if / wsd_out_if and the decoder RTL.
module tb;
  import wsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_CYCLES = 60;
  localparam int SETTLE       = 8;

  typedef enum logic [2:0] {PH_FIRST, PH_SECOND, PH_EXTLEN, PH_KEY, PH_BODY} parse_phase_t;
  typedef enum logic [1:0] {LEN7, LEN16, LEN64} len_form_t;

  logic clk = 1'b0;
  logic rst_n;
  logic rx_hold = 1'b0;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   err_count;
  int   sent_bytes;
  int   cycles;
  event stall_go;

  // predictor state
  parse_phase_t ph;
  int           hdr_left;
  logic         fin_q;
  logic [3:0]   opc_q;
  logic         masked_q;
  logic [31:0]  key_q;
  logic [62:0]  len_q;
  logic [62:0]  left_q;
  logic [1:0]   key_pos;
  wsd_result_t  pending_words[$];

  wsd_in_if  in_ch ();
  wsd_out_if out_ch ();

  websocket_frame_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic void push_word(input logic [7:0] data, input logic last, input logic empty);
    wsd_result_t w;
    w.payload_byte  = data;
    w.fin           = fin_q;
    w.opcode        = opc_q;
    w.was_masked    = masked_q;
    w.frame_length  = len_q;
    w.last_of_frame = last;
    w.empty_frame   = empty;
    pending_words = {pending_words, w};
  endfunction

  function automatic void header_complete();
    if (len_q == '0) begin
      push_word(8'h00, 1'b1, 1'b1);
      ph = PH_FIRST;
    end else begin
      left_q  = len_q;
      key_pos = 2'd0;
      ph      = PH_BODY;
    end
  endfunction

  // Advance the parse by one accepted byte; queue the word it yields, if any.
  function automatic void decode_byte(input logic [7:0] b);
    logic [7:0] k;
    case (ph)
      PH_FIRST: begin
        fin_q = b[7];
        opc_q = b[3:0];
        ph    = PH_SECOND;
      end
      PH_SECOND: begin
        masked_q = b[7];
        key_q    = '0;
        if (b[6:0] == 7'd127 || b[6:0] == 7'd126) begin
          len_q    = '0;
          hdr_left = (b[6:0] == 7'd127) ? 8 : 2;
          ph       = PH_EXTLEN;
        end else begin
          len_q = 63'(b[6:0]);
          if (masked_q) begin
            hdr_left = 4;
            ph       = PH_KEY;
          end else begin
            header_complete();
          end
        end
      end
      PH_EXTLEN: begin
        len_q = {len_q[54:0], b};  // top bit of a 64-bit length falls off
        hdr_left--;
        if (hdr_left == 0) begin
          if (masked_q) begin
            hdr_left = 4;
            ph       = PH_KEY;
          end else begin
            header_complete();
          end
        end
      end
      PH_KEY: begin
        key_q = {key_q[23:0], b};
        hdr_left--;
        if (hdr_left == 0) header_complete();
      end
      default: begin
        k = masked_q ? key_q[8*(3-key_pos) +: 8] : 8'h00;
        key_pos++;
        if (left_q != '0) left_q--;
        push_word(b ^ k, left_q == '0, 1'b0);
        if (left_q == '0) ph = PH_FIRST;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [62:0] exp,
                                      input logic [62:0] got);
    if (exp !== got) begin
      $error("%s: expected %0h, got %0h", name, exp, got);
      err_count++;
    end
  endfunction

  function automatic void check_word();
    wsd_result_t exp;
    if (pending_words.size() == 0) begin
      $error("result word with nothing expected");
      err_count++;
      return;
    end
    exp = pending_words.pop_front();
    // payload is don't-care on an empty frame
    if (!exp.empty_frame) check_field("payload_byte", 63'(exp.payload_byte), 63'(out_ch.payload_byte));
    check_field("fin", 63'(exp.fin), 63'(out_ch.fin));
    check_field("opcode", 63'(exp.opcode), 63'(out_ch.opcode));
    check_field("was_masked", 63'(exp.was_masked), 63'(out_ch.was_masked));
    check_field("frame_length", exp.frame_length, out_ch.frame_length);
    check_field("last_of_frame", 63'(exp.last_of_frame), 63'(out_ch.last_of_frame));
    check_field("empty_frame", 63'(exp.empty_frame), 63'(out_ch.empty_frame));
  endfunction

  // Result side: random ready, long hold on request, check on handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word();
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always begin
    @(stall_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b);
    sent_bytes++;
  endtask

  task automatic send_frame(input logic [7:0] b0, input logic masked, input len_form_t form,
                            input logic [63:0] len_field, input logic [31:0] key,
                            input int nbody);
    send_byte(b0);
    case (form)
      LEN7: send_byte({masked, len_field[6:0]});
      LEN16: begin
        send_byte({masked, 7'd126});
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
      end
      default: begin
        send_byte({masked, 7'd127});
        for (int i = 7; i >= 0; i--) send_byte(len_field[8*i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (int i = 0; i < nbody; i++) send_byte(8'($urandom));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Zero-length frames across all opcodes, with random reserved bits.
  task automatic test_opcodes();
    logic [7:0] b0;
    for (int op = 0; op < 16; op++) begin
      b0 = {1'(op), 3'($urandom), 4'(op)};
      send_frame(b0, 1'b0, LEN7, 64'd0, 32'h0, 0);
    end
  endtask

  task automatic test_length_forms();
    send_frame(8'h81, 1'b1, LEN7, 64'd0, $urandom, 0);
    send_frame(8'h02, 1'b0, LEN7, 64'd1, 32'h0, 1);
    send_frame(8'h82, 1'b1, LEN7, 64'd6, 32'hA5C3_0FF0, 6);      // key wraps round
    send_frame(8'h89, 1'b1, LEN7, 64'd125, $urandom, 125);
    send_frame(8'h01, 1'b0, LEN16, 64'd0, 32'h0, 0);
    send_frame(8'h80, 1'b1, LEN16, 64'd5, $urandom, 5);          // non-minimal
    send_frame(8'hF2, 1'b0, LEN64, 64'h8000_0000_0000_0003, 32'h0, 3);
    send_frame(8'h8A, 1'b1, LEN64, 64'h8000_0000_0000_0000, $urandom, 0);
    send_frame(8'h08, 1'b1, LEN64, 64'd20, 32'hFFFF_FFFF, 20);
  endtask

  task automatic test_receiver_stall();
    -> stall_go;
    send_frame(8'h82, 1'b1, LEN7, 64'd40, $urandom, 40);
    wait_drained();
  endtask

  task automatic random_frame();
    logic       masked;
    len_form_t  form;
    logic [63:0] lf;
    int         sel;
    int         nbody;
    masked = 1'($urandom);
    sel    = $urandom_range(99);
    if (sel < 60) begin
      form  = LEN7;
      nbody = $urandom_range(12);
      lf    = 64'(nbody);
    end else if (sel < 70) begin
      form  = LEN7;
      nbody = $urandom_range(125);
      lf    = 64'(nbody);
    end else if (sel < 85) begin
      form  = LEN16;
      nbody = $urandom_range(300);
      lf    = 64'(nbody);
    end else begin
      form  = LEN64;
      nbody = $urandom_range(40);
      lf    = {1'($urandom), 55'd0, 8'(nbody)};
    end
    send_frame(8'($urandom), masked, form, lf, $urandom, nbody);
  endtask

  task automatic test_random(input int n);
    int target;
    target = sent_bytes + n;
    while (sent_bytes < target) random_frame();
  endtask

  // Length with every bit set: only the start of the body is sent.
  task automatic test_huge_length();
    send_frame(8'h82, 1'b1, LEN64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 20);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    out_ch.ready    = 1'b0;
    err_count       = 0;
    sent_bytes      = 0;
    cycles          = 0;
    ph              = PH_FIRST;
    hdr_left        = 0;
    fin_q           = 1'b0;
    opc_q           = 4'h0;
    masked_q        = 1'b0;
    key_q           = '0;
    len_q           = '0;
    left_q          = '0;
    key_pos         = 2'd0;
    send_idle_pct   = 38;
    recv_idle_pct   = 55;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_opcodes();
    test_length_forms();
    test_receiver_stall();
    test_random(30);
    wait_drained();
    send_idle_pct = 55;
    recv_idle_pct = 38;
    test_random(30);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(30);
    test_huge_length();
    wait_drained();

    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/wsd_pkg.sv
src/wsd_if.sv
src/wsd_parser.sv
src/websocket_frame_decoder.sv
tb/sv/tb.sv
